[hdl/bap_pkg.sv]
// Shared types and constants for the block-average pixelation unit.
// No dependencies; every other file but bap_ram imports this package.
package bap_pkg;

  localparam int PIX_W     = 8;   // one color component
  localparam int ROW_W     = 16;  // row position and image height
  localparam int OCOL_W    = 10;  // column field of a result beat
  localparam int WIDTH_W   = 11;  // image_width register
  localparam int CFG_W     = 16;  // widest configuration register
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W_MAX = 14;  // holds 8*8*255, the largest block sum

  // Block descriptor queue between the front and the back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [ROW_W-1:0]   HEIGHT_RST = 16'd480;

  // One finished block: origin and the three channel sums (red, green, blue)
  typedef struct packed {
    logic [ROW_W-1:0]                row0;
    logic [OCOL_W-1:0]               col0;
    logic [2:0][SUM_W_MAX-1:0]       sum;
  } desc_t;

  // Free space of the descriptor queue as seen by the front
  typedef struct packed {
    logic room1;
    logic room2;
  } q_status_t;

endpackage

[hdl/bap_ifs.sv]
// Valid/ready channel interfaces: pixel input and result output.
// Depends on bap_pkg for field widths.
interface bap_pix_if;
  import bap_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface bap_res_if;
  import bap_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  out_row;
  logic [OCOL_W-1:0] out_col;
  logic [PIX_W-1:0]  red_avg;
  logic [PIX_W-1:0]  green_avg;
  logic [PIX_W-1:0]  blue_avg;
  logic              block_done;
  modport source (output valid, output out_row, output out_col, output red_avg,
                  output green_avg, output blue_avg, output block_done, input ready);
  modport sink   (input valid, input out_row, input out_col, input red_avg,
                  input green_avg, input blue_avg, input block_done, output ready);
endinterface

[hdl/bap_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module bap_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/bap_front.sv]
// Front end: configuration, raster position tracking, block classification
// and the per-block sum accumulation. Depends on bap_pkg, bap_ifs, bap_ram.
module bap_front #(
  parameter int BLOCK_SIZE = 4,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bap_pix_if.sink                      pix,
  input  logic                         cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bap_pkg::CFG_W-1:0]    cfg_data,
  input  bap_pkg::q_status_t           q_status,
  output logic                         push,
  output bap_pkg::desc_t               push_desc
);
  import bap_pkg::*;

  localparam int AREA    = BLOCK_SIZE * BLOCK_SIZE;
  localparam int SUM_MAX = AREA * 255;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int NBLOCKS = MAX_WIDTH / BLOCK_SIZE;
  localparam int ADDR_W  = $clog2(NBLOCKS);
  localparam int BC_W    = $clog2(NBLOCKS + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH + 1);
  localparam int CW1     = COL_W + 1;
  localparam int RW1     = ROW_W + 1;
  localparam int SW1     = SUM_W + 1;
  localparam int SUB_W   = $clog2(BLOCK_SIZE);

  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(BLOCK_SIZE - 1);

  logic [WIDTH_W-1:0] width_r;
  logic [ROW_W-1:0]   height_r;
  logic [COL_W-1:0]   w_eff;
  logic [ROW_W-1:0]   h_eff;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] bstart_r, bstart_nxt;
  logic [SUB_W-1:0] sub_c_r, sub_c_nxt;
  logic [BC_W-1:0]  bc_r, bc_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [ROW_W-1:0] rstart_r, rstart_nxt;
  logic [SUB_W-1:0] sub_r_r, sub_r_nxt;

  logic accept, in_block, first_px, last_px, col_end, row_end;

  logic                   s1_valid_r, s1_first_r, s1_last_r;
  logic [ADDR_W-1:0]      s1_addr_r;
  logic [2:0][PIX_W-1:0]  s1_pix_r;
  logic [ROW_W-1:0]       s1_row0_r;
  logic [OCOL_W-1:0]      s1_col0_r;

  logic                   fwd_valid_r;
  logic [ADDR_W-1:0]      fwd_addr_r;
  logic [2:0][SUM_W-1:0]  fwd_sum_r;

  logic [2:0][SUM_W-1:0]  rd_sum, old_sum, new_sum;
  logic [SW1-1:0]         add_sum [3];
  logic                   ram_re;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the image size to what the block handles
  always_comb begin
    if (32'(width_r) < BLOCK_SIZE) begin
      w_eff = COL_W'(BLOCK_SIZE);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = COL_W'(width_r);
    end
    h_eff = (32'(height_r) < BLOCK_SIZE) ? ROW_W'(BLOCK_SIZE) : height_r;
  end

  // Classify the incoming pixel against its block
  assign in_block = ((CW1'(bstart_r) + CW1'(BLOCK_SIZE)) <= CW1'(w_eff)) &&
                    ((RW1'(rstart_r) + RW1'(BLOCK_SIZE)) <= RW1'(h_eff));
  assign first_px = (sub_c_r == '0) && (sub_r_r == '0);
  assign last_px  = (sub_c_r == SUB_LAST) && (sub_r_r == SUB_LAST);
  assign col_end  = (CW1'(col_r) + CW1'(1)) >= CW1'(w_eff);
  assign row_end  = (RW1'(row_r) + RW1'(1)) >= RW1'(h_eff);

  // Take a beat only if the queue can hold whatever is still in flight
  assign pix.ready = q_status.room2 || (q_status.room1 && !(s1_valid_r && s1_last_r));
  assign accept    = pix.valid && pix.ready;

  // Advance the raster position
  always_comb begin
    col_nxt    = col_r;
    bstart_nxt = bstart_r;
    sub_c_nxt  = sub_c_r;
    bc_nxt     = bc_r;
    row_nxt    = row_r;
    rstart_nxt = rstart_r;
    sub_r_nxt  = sub_r_r;
    if (accept) begin
      if (col_end) begin
        col_nxt    = '0;
        bstart_nxt = '0;
        sub_c_nxt  = '0;
        bc_nxt     = '0;
        if (row_end) begin
          row_nxt    = '0;
          rstart_nxt = '0;
          sub_r_nxt  = '0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
          if (sub_r_r == SUB_LAST) begin
            sub_r_nxt  = '0;
            rstart_nxt = rstart_r + ROW_W'(BLOCK_SIZE);
          end else begin
            sub_r_nxt = sub_r_r + SUB_W'(1);
          end
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
        if (sub_c_r == SUB_LAST) begin
          sub_c_nxt  = '0;
          bstart_nxt = bstart_r + COL_W'(BLOCK_SIZE);
          bc_nxt     = bc_r + BC_W'(1);
        end else begin
          sub_c_nxt = sub_c_r + SUB_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      bstart_r <= '0;
      sub_c_r  <= '0;
      bc_r     <= '0;
      row_r    <= '0;
      rstart_r <= '0;
      sub_r_r  <= '0;
    end else begin
      col_r    <= col_nxt;
      bstart_r <= bstart_nxt;
      sub_c_r  <= sub_c_nxt;
      bc_r     <= bc_nxt;
      row_r    <= row_nxt;
      rstart_r <= rstart_nxt;
      sub_r_r  <= sub_r_nxt;
    end
  end

  // Hand the accepted pixel to the accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept && in_block;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first_r <= first_px;
      s1_last_r  <= last_px;
      s1_addr_r  <= bc_r[ADDR_W-1:0];
      s1_pix_r   <= {pix.blue_in, pix.green_in, pix.red_in};
      s1_row0_r  <= rstart_r;
      s1_col0_r  <= OCOL_W'(bstart_r);
    end
  end

  assign ram_re = accept && in_block && !first_px;

  bap_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (NBLOCKS)
  ) u_sums (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (new_sum),
    .re    (ram_re),
    .raddr (bc_r[ADDR_W-1:0]),
    .rdata (rd_sum)
  );

  // Accumulate: bypass the sum written on the previous edge, saturate the add
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      old_sum[ch] = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_sum_r[ch] : rd_sum[ch];
      add_sum[ch] = SW1'(old_sum[ch]) + SW1'(s1_pix_r[ch]);
      if (s1_first_r) begin
        new_sum[ch] = SUM_W'(s1_pix_r[ch]);
      end else if (add_sum[ch] > SW1'(SUM_MAX)) begin
        new_sum[ch] = SUM_W'(SUM_MAX);
      end else begin
        new_sum[ch] = add_sum[ch][SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr_r;
    fwd_sum_r  <= new_sum;
  end

  // Push a descriptor when a block completes
  assign push           = s1_valid_r && s1_last_r;
  assign push_desc.row0 = s1_row0_r;
  assign push_desc.col0 = s1_col0_r;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      push_desc.sum[ch] = SUM_W_MAX'(new_sum[ch]);
    end
  end

endmodule

[hdl/bap_queue.sv]
// Short descriptor queue that decouples accumulation from burst output.
// Depends on bap_pkg.
module bap_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bap_pkg::desc_t     push_desc,
  input  logic               pop,
  output logic               head_valid,
  output bap_pkg::desc_t     head_desc,
  output bap_pkg::q_status_t q_status
);
  import bap_pkg::*;

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] count_r;

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_desc;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign head_valid     = (count_r != '0);
  assign head_desc      = mem_r[rptr_r];
  assign q_status.room1 = (count_r < QCNT_W'(QDEPTH));
  assign q_status.room2 = (count_r <= QCNT_W'(QDEPTH - 2));

endmodule

[hdl/bap_back.sv]
// Back end: turns block descriptors into bursts of result beats.
// Computes the block averages and drives the output register. Depends on bap_pkg, bap_ifs.
module bap_back #(
  parameter int BLOCK_SIZE = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  bap_pkg::desc_t head_desc,
  output logic           pop,
  bap_res_if.source      res
);
  import bap_pkg::*;

  // Division by the block area as a reciprocal multiply, exact below 2**SUM_W_MAX
  localparam int AREA  = BLOCK_SIZE * BLOCK_SIZE;
  localparam int LOG_A = $clog2(AREA);
  localparam int SHIFT = SUM_W_MAX + LOG_A;
  localparam int RECIP = ((1 << SHIFT) + AREA - 1) / AREA;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = SUM_W_MAX + RW;
  localparam int SUB_W = $clog2(BLOCK_SIZE);

  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(BLOCK_SIZE - 1);

  logic                  active_r;
  logic [ROW_W-1:0]      row0_r;
  logic [OCOL_W-1:0]     col0_r;
  logic [2:0][PIX_W-1:0] avg_r, avg_nxt;
  logic [SUB_W-1:0]      bi_r, bj_r;
  logic [PW-1:0]         prod [3];

  logic                  out_valid_r;
  logic [ROW_W-1:0]      out_row_r;
  logic [OCOL_W-1:0]     out_col_r;
  logic [2:0][PIX_W-1:0] out_avg_r;
  logic                  out_done_r;

  logic advance, last_beat;

  assign advance   = active_r && (!out_valid_r || res.ready);
  assign last_beat = (bi_r == SUB_LAST) && (bj_r == SUB_LAST);
  assign pop       = head_valid && (!active_r || (advance && last_beat));

  // Averages of the head descriptor
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]    = PW'(head_desc.sum[ch]) * PW'(RECIP);
      avg_nxt[ch] = PIX_W'(prod[ch] >> SHIFT);
    end
  end

  // Load a new burst or step through the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (pop) begin
      active_r <= 1'b1;
    end else if (advance && last_beat) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row0_r <= head_desc.row0;
      col0_r <= head_desc.col0;
      avg_r  <= avg_nxt;
      bi_r   <= '0;
      bj_r   <= '0;
    end else if (advance) begin
      if (bj_r == SUB_LAST) begin
        bj_r <= '0;
        bi_r <= bi_r + SUB_W'(1);
      end else begin
        bj_r <= bj_r + SUB_W'(1);
      end
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_row_r  <= row0_r + ROW_W'(bi_r);
      out_col_r  <= col0_r + OCOL_W'(bj_r);
      out_avg_r  <= avg_r;
      out_done_r <= last_beat;
    end
  end

  assign res.valid      = out_valid_r;
  assign res.out_row    = out_row_r;
  assign res.out_col    = out_col_r;
  assign res.red_avg    = out_avg_r[0];
  assign res.green_avg  = out_avg_r[1];
  assign res.blue_avg   = out_avg_r[2];
  assign res.block_done = out_done_r;

endmodule

[hdl/block_average_pixelate_unit.sv]
// Top level of the block-average pixelation unit: front, descriptor queue, back.
// Depends on bap_pkg, bap_ifs, bap_front, bap_queue, bap_back.
//
//   channel  direction  handshake          payload
//   in_pix   in         valid/ready        red_in, green_in, blue_in
//   out_res  out        valid/ready        out_row, out_col, red/green/blue_avg, block_done
//   cfg      in         cfg_we, no stall   cfg_index, cfg_data
//
// One pixel is accepted per cycle; the block sum is read, updated and written back
// in a two-stage loop with a one-entry bypass. A finished block passes from the
// accumulate stage through the descriptor queue to the output register and then
// leaves as BLOCK_SIZE*BLOCK_SIZE beats, one per cycle while out_res is ready.
// The input stalls only when the four-entry block queue lacks room, which
// happens along the bottom row of a band. Reset clears position and control
// state; the sum memory needs no clearing pass.
module block_average_pixelate_unit #(
  parameter int BLOCK_SIZE = 4,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bap_pix_if.sink                       in_pix,
  bap_res_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bap_pkg::CFG_W-1:0]     cfg_data
);
  import bap_pkg::*;

  q_status_t q_status;
  logic      push, pop, head_valid;
  desc_t     push_desc, head_desc;

  bap_front #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix       (in_pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_desc (push_desc)
  );

  bap_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .q_status   (q_status)
  );

  bap_back #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .res        (out_res)
  );

endmodule

[tb/sv/block_average_pixelate_unit_test.sv]
// Self-checking testbench for block_average_pixelate_unit: random pixel bursts in, averaged
// mosaic beats out, each beat checked against an in-bench 4x4 block-average predictor.
// Depends on bap_pkg, bap_ifs and the unit under test; reads no files.
module block_average_pixelate_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bap_pkg::*;

  localparam int BLK         = 4;
  localparam int MAXW        = 1024;
  localparam int AREA        = BLK * BLK;
  localparam int NBLK        = MAXW / BLK;
  localparam int SUM_MAX     = AREA * 255;
  localparam int SETTLE      = 12;
  localparam int RAND_PHASES = 5;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic              last;
  } mosaic_beat_t;

  typedef enum logic [1:0] {RDY_OPEN, RDY_COIN, RDY_SPARSE, RDY_STUTTER} ready_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bap_pix_if pix_if ();
  bap_res_if res_if ();

  block_average_pixelate_unit #(
    .BLOCK_SIZE(BLK),
    .MAX_WIDTH (MAXW)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: register copies, raster position and per-block running sums
  logic [WIDTH_W-1:0] width_reg  = WIDTH_RST;
  logic [ROW_W-1:0]   height_reg = HEIGHT_RST;
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;
  int unsigned        band_sums [0:NBLK-1][0:2];

  rgb_t         pixel_q[$];
  mosaic_beat_t avg_beats_q[$];

  int errors = 0;
  int pixels_taken = 0;
  int beats_checked = 0;
  int blocks_predicted = 0;
  int settings_used = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;

  ready_mode_t ready_mode;
  int          mode_left;
  logic [3:0]  stall_phase;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(width_reg);
    if (w < BLK) w = BLK;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = 32'(height_reg);
    if (h < BLK) h = BLK;
    return h;
  endfunction

  // Fold one accepted pixel into its block; queue the 16 averaged beats when a block closes
  task automatic absorb_pixel(input rgb_t px);
    int unsigned  w, h, bc, sc, sr, r0, c0;
    int unsigned  chan [0:2];
    int unsigned  avg [0:2];
    logic [31:0]  pos;
    mosaic_beat_t beat;
    w = eff_width();
    h = eff_height();
    chan[0] = 32'(px.red);
    chan[1] = 32'(px.green);
    chan[2] = 32'(px.blue);
    bc = col_pos / BLK;
    sc = col_pos % BLK;
    sr = row_pos % BLK;
    if (bc < NBLK && (bc + 1) * BLK <= w && (row_pos / BLK + 1) * BLK <= h) begin
      for (int k = 0; k < 3; k++) begin
        if (sr == 0 && sc == 0) begin
          band_sums[bc][k] = chan[k];
        end else begin
          band_sums[bc][k] = band_sums[bc][k] + chan[k];
          if (band_sums[bc][k] > SUM_MAX) band_sums[bc][k] = SUM_MAX;
        end
      end
      if (sr == BLK - 1 && sc == BLK - 1) begin
        for (int k = 0; k < 3; k++) begin
          avg[k] = band_sums[bc][k] / AREA;
          if (avg[k] > 255) avg[k] = 255;
        end
        r0 = row_pos - (BLK - 1);
        c0 = col_pos - (BLK - 1);
        for (int i = 0; i < BLK; i++) begin
          for (int j = 0; j < BLK; j++) begin
            pos = r0 + i;
            beat.row = pos[ROW_W-1:0];
            pos = c0 + j;
            beat.col = pos[OCOL_W-1:0];
            beat.red = avg[0][PIX_W-1:0];
            beat.green = avg[1][PIX_W-1:0];
            beat.blue = avg[2][PIX_W-1:0];
            beat.last = (i == BLK - 1 && j == BLK - 1);
            avg_beats_q.push_back(beat);
          end
        end
        blocks_predicted++;
      end
    end
    // Advance the raster position; wrap column at the width and row at the height
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  function automatic rgb_t rand_pixel();
    logic [PIX_W-1:0] ch [0:2];
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 7))
        0: ch[k] = '0;
        1: ch[k] = '1;
        default: ch[k] = PIX_W'($urandom_range(0, 255));
      endcase
    end
    return {ch[0], ch[1], ch[2]};
  endfunction

  task automatic queue_random(input int n);
    repeat (n) pixel_q.push_back(rand_pixel());
  endtask

  task automatic queue_flat(input int n, input logic [PIX_W-1:0] v);
    repeat (n) pixel_q.push_back({v, v, v});
  endtask

  // Hold until every pixel is taken and every beat has arrived, then let the pipe empty
  task automatic settle(input int extra);
    do @(negedge clk);
    while (pixel_q.size() != 0 || pix_if.valid || avg_beats_q.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Write both size registers on consecutive edges; junk in the unused width bits
  task automatic program_size(input int unsigned w, input int unsigned h);
    logic [CFG_W-1:0] wdata;
    wdata = CFG_W'($urandom);
    wdata[WIDTH_W-1:0] = w[WIDTH_W-1:0];
    width_reg = wdata[WIDTH_W-1:0];
    height_reg = h[ROW_W-1:0];
    cfg_we <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data <= wdata;
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data <= h[ROW_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Feed random pixels until the next pixel starts a band, so a size change is safe
  task automatic pad_to_band_top();
    int unsigned c, r, w, h, n;
    c = col_pos;
    r = row_pos;
    w = eff_width();
    h = eff_height();
    n = 0;
    while (!(c == 0 && r % BLK == 0)) begin
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c = c + 1;
      end
      n++;
    end
    queue_random(n);
  endtask

  // Pixel driver: bursts of random length separated by random gaps
  always @(posedge clk) begin : pixel_driver
    rgb_t px;
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
      pix_if.red_in <= '0;
      pix_if.green_in <= '0;
      pix_if.blue_in <= '0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        absorb_pixel({pix_if.red_in, pix_if.green_in, pix_if.blue_in});
        pixels_taken++;
      end
      // Hold the beat while it is stalled
      if (!(pix_if.valid && !pix_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_if.valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          px = pixel_q.pop_front();
          pix_if.valid <= 1'b1;
          pix_if.red_in <= px.red;
          pix_if.green_in <= px.green;
          pix_if.blue_in <= px.blue;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: switch between open, coin-flip, sparse and stuttering patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      ready_mode <= RDY_OPEN;
      mode_left <= 0;
      stall_phase <= '0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      if (mode_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(64, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        RDY_OPEN:    res_if.ready <= 1'b1;
        RDY_COIN:    res_if.ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE:  res_if.ready <= (stall_phase[1:0] == 2'd0);
        RDY_STUTTER: res_if.ready <= (stall_phase >= 4'd10);
      endcase
    end
  end

  function automatic void check_field(input string fname, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want_v, got_v);
    end
  endfunction

  // Result monitor: compare each beat with the oldest predicted beat
  always @(posedge clk) begin : result_monitor
    mosaic_beat_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (avg_beats_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got row %0d col %0d", $time,
                 res_if.out_row, res_if.out_col);
      end else begin
        want = avg_beats_q.pop_front();
        check_field("out_row", 32'(want.row), 32'(res_if.out_row));
        check_field("out_col", 32'(want.col), 32'(res_if.out_col));
        check_field("red_avg", 32'(want.red), 32'(res_if.red_avg));
        check_field("green_avg", 32'(want.green), 32'(res_if.green_avg));
        check_field("blue_avg", 32'(want.blue), 32'(res_if.blue_avg));
        check_field("block_done", 32'(want.last), 32'(res_if.block_done));
        beats_checked++;
      end
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Watchdog
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned w, h;
    cfg_we = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size: start the top band with white, then shrink both registers below range
    // while the column sits past the new width; that pixel drops and the row advances
    queue_flat(5, 8'hFF);
    settle(SETTLE);
    program_size(3, 2);
    queue_random(1);
    queue_flat(12, 8'hFF);
    settle(SETTLE);
    queue_flat(16, 8'h00);
    settle(SETTLE);

    // Width register above range clamps to the widest image: open the top row of a band
    // there, then narrow to two blocks; the next pixel lies past the new width and drops,
    // and the three rows below close both blocks on the sums begun at the wide setting
    program_size(2047, 4);
    queue_random(10 * BLK);
    settle(SETTLE);
    program_size(2 * BLK, 4);
    queue_random(1 + 3 * 2 * BLK);
    settle(SETTLE);

    // Random sizes: tallest height, heights below range, odd widths with partial blocks
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          w = BLK;
          h = 65535;
        end
        1: begin
          w = $urandom_range(5, 13);
          h = $urandom_range(0, 3);
        end
        default: begin
          w = $urandom_range(4, 13);
          h = $urandom_range(4, 14);
        end
      endcase
      program_size(w, h);
      queue_random($urandom_range(10, 24));
      settle(SETTLE);
      pad_to_band_top();
      settle(SETTLE);
    end

    settle(SETTLE * 2);
    $display("Run: %0d pixels in, %0d beats checked, %0d blocks", pixels_taken,
             beats_checked, blocks_predicted);
    $display("Sizes: %0d register settings, %0d mismatches", settings_used, errors);
    if (errors == 0 && avg_beats_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[block_average_pixelate_unit.f]
hdl/bap_pkg.sv
hdl/bap_ifs.sv
hdl/bap_ram.sv
hdl/bap_front.sv
hdl/bap_queue.sv
hdl/bap_back.sv
hdl/block_average_pixelate_unit.sv
tb/sv/block_average_pixelate_unit_test.sv
